// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL. Both sample on i_clk and are
// disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_AT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/flba_pkg.sv -----
package flba_pkg;

    localparam int FIELD_W = 16;
    localparam int STORE_W = 17;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NO_FIT = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_ALLOC_DEC,
        S_FREE_JOIN,
        S_FREE_DEC,
        S_MOVE,
        S_INS,
        S_DONE
    } t_state;

endpackage

// ----- rtl/free_list_block_allocator_core.sv -----
// Free-list block allocator over a byte arena.
// Input channel (i_valid / o_stall) carries one word per request: i_opcode
// selects allocate or free, with i_request_bytes or i_free_offset_in.
// Output channel (o_valid / i_stall) returns one word per request: o_status,
// o_data_offset and o_granted_bytes.
// The configuration channel (i_cfg_valid / o_cfg_ready) writes best-fit mode;
// it is always ready. It is to be written only while the block is idle, a rule
// for the user that the block itself does not enforce. One request is worked
// at a time by a sequencer around a segment table with one read and one write
// port: a scan reads one entry per cycle, then entries are shifted one per
// cycle when a segment is removed or inserted. The next word can be taken in
// the cycle in which o_valid rises.
// o_stall is high from acceptance until the result is moved into the output
// register. A result waiting on i_stall does not block acceptance of the
// next word, but that word cannot finish until the output register empties.
// After reset the table holds one free segment covering the whole arena,
// first fit is selected, and the block is ready at once.
`include "assert_macros.svh"

module free_list_block_allocator_core import flba_pkg::*; #(
    parameter int ARENA_BYTES = 65536,
    parameter int MAX_SEGMENTS = 64,
    parameter int GRANULE_BYTES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_opcode,
    input  logic [FIELD_W-1:0] i_request_bytes,
    input  logic [FIELD_W-1:0] i_free_offset_in,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_status,
    output logic [FIELD_W-1:0] o_data_offset,
    output logic [FIELD_W-1:0] o_granted_bytes,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_best_fit_mode
);

    localparam int AW = $clog2(ARENA_BYTES);
    localparam int VW = ((AW > STORE_W) ? AW : STORE_W) + 2;
    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int GSH = $clog2(GRANULE_BYTES);
    localparam int SDEPTH = ARENA_BYTES / GRANULE_BYTES;
    localparam int EW = AW + VW;
    localparam logic [VW-1:0] G_V = VW'(GRANULE_BYTES);
    localparam logic [VW-1:0] ARENA_V = VW'(ARENA_BYTES);
    localparam logic [VW-1:0] ONE_V = VW'(1);
    localparam logic [CW-1:0] MAX_C = CW'(MAX_SEGMENTS);
    localparam logic [CW-1:0] ONE_C = CW'(1);
    localparam logic [EW-1:0] INIT_ENTRY = {AW'(0), ARENA_V - G_V};

    t_state r_state, n_state;
    logic r_op, n_op;
    logic r_best;
    logic [VW-1:0] r_need, n_need;
    logic [AW-1:0] r_node, n_node;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_rd_idx, n_rd_idx;
    logic r_chk_v, n_chk_v;
    logic [CW-1:0] r_chk_idx, n_chk_idx;
    logic r_found, n_found;
    logic [CW-1:0] r_pick_idx, n_pick_idx;
    logic [AW-1:0] r_pick_start, n_pick_start;
    logic [VW-1:0] r_pick_bytes, n_pick_bytes;
    logic r_has_prev, n_has_prev;
    logic [AW-1:0] r_prev_start, n_prev_start;
    logic [VW-1:0] r_prev_bytes, n_prev_bytes;
    logic r_has_next, n_has_next;
    logic [AW-1:0] r_next_start, n_next_start;
    logic [VW-1:0] r_next_bytes, n_next_bytes;
    logic [CW-1:0] r_i, n_i;
    logic r_jn, n_jn;
    logic r_jp, n_jp;
    logic [VW-1:0] r_tail, n_tail;
    logic [VW-1:0] r_mid, n_mid;
    logic [CW-1:0] r_mv_src, n_mv_src;
    logic [CW-1:0] r_mv_cnt, n_mv_cnt;
    logic r_mv_up, n_mv_up;
    logic r_mv_pend, n_mv_pend;
    logic [CW-1:0] r_mv_dst, n_mv_dst;
    logic [1:0] r_res_status, n_res_status;
    logic [FIELD_W-1:0] r_res_off, n_res_off;
    logic [FIELD_W-1:0] r_res_gr, n_res_gr;
    logic r_ov, n_ov;
    logic [1:0] r_o_status, n_o_status;
    logic [FIELD_W-1:0] r_o_off, n_o_off;
    logic [FIELD_W-1:0] r_o_gr, n_o_gr;
    logic [STORE_W-1:0] r_size;

    logic [IW-1:0] tbl_ra;
    logic tbl_we;
    logic [IW-1:0] tbl_wa;
    logic [EW-1:0] tbl_wd;
    logic [EW-1:0] tbl_q;
    logic [AW-1:0] q_start;
    logic [VW-1:0] q_bytes;

    logic st_we;
    logic [STORE_W-1:0] st_wd;
    logic [STORE_W-1:0] hdr_store [SDEPTH];

    logic [VW-1:0] off_v;
    logic [VW-1:0] node_v;
    logic [VW-1:0] size_v;
    logic [VW-1:0] gr_v;
    logic [CW-1:0] im1;

    flba_seg_table #(
        .DEPTH(MAX_SEGMENTS),
        .IW(IW),
        .EW(EW),
        .INIT_ENTRY(INIT_ENTRY)
    ) u_table (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_rd_addr(tbl_ra),
        .i_wr_en(tbl_we),
        .i_wr_addr(tbl_wa),
        .i_wr_data(tbl_wd),
        .o_rd_data(tbl_q)
    );

    assign q_start = tbl_q[EW-1:VW];
    assign q_bytes = tbl_q[VW-1:0];
    assign size_v = VW'(r_size);
    assign off_v = VW'(i_free_offset_in);
    assign node_v = off_v - G_V;
    assign im1 = r_i - ONE_C;

    // Header size store: one write at the end of an allocate, and a read of
    // the freed block's header every cycle.
    always_ff @(posedge i_clk) begin
        if (st_we) begin
            hdr_store[r_pick_start[AW-1:GSH]] <= st_wd;
        end
        r_size <= hdr_store[r_node[AW-1:GSH]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_best  <= 1'b0;
            r_count <= ONE_C;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ov    <= n_ov;
            if (i_cfg_valid) begin
                r_best <= i_cfg_best_fit_mode;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_need       <= n_need;
        r_node       <= n_node;
        r_rd_idx     <= n_rd_idx;
        r_chk_v      <= n_chk_v;
        r_chk_idx    <= n_chk_idx;
        r_found      <= n_found;
        r_pick_idx   <= n_pick_idx;
        r_pick_start <= n_pick_start;
        r_pick_bytes <= n_pick_bytes;
        r_has_prev   <= n_has_prev;
        r_prev_start <= n_prev_start;
        r_prev_bytes <= n_prev_bytes;
        r_has_next   <= n_has_next;
        r_next_start <= n_next_start;
        r_next_bytes <= n_next_bytes;
        r_i          <= n_i;
        r_jn         <= n_jn;
        r_jp         <= n_jp;
        r_tail       <= n_tail;
        r_mid        <= n_mid;
        r_mv_src     <= n_mv_src;
        r_mv_cnt     <= n_mv_cnt;
        r_mv_up      <= n_mv_up;
        r_mv_pend    <= n_mv_pend;
        r_mv_dst     <= n_mv_dst;
        r_res_status <= n_res_status;
        r_res_off    <= n_res_off;
        r_res_gr     <= n_res_gr;
        r_o_status   <= n_o_status;
        r_o_off      <= n_o_off;
        r_o_gr       <= n_o_gr;
    end

    always_comb begin
        n_state = r_state;
        n_op = r_op;
        n_need = r_need;
        n_node = r_node;
        n_count = r_count;
        n_rd_idx = r_rd_idx;
        n_chk_v = r_chk_v;
        n_chk_idx = r_chk_idx;
        n_found = r_found;
        n_pick_idx = r_pick_idx;
        n_pick_start = r_pick_start;
        n_pick_bytes = r_pick_bytes;
        n_has_prev = r_has_prev;
        n_prev_start = r_prev_start;
        n_prev_bytes = r_prev_bytes;
        n_has_next = r_has_next;
        n_next_start = r_next_start;
        n_next_bytes = r_next_bytes;
        n_i = r_i;
        n_jn = r_jn;
        n_jp = r_jp;
        n_tail = r_tail;
        n_mid = r_mid;
        n_mv_src = r_mv_src;
        n_mv_cnt = r_mv_cnt;
        n_mv_up = r_mv_up;
        n_mv_pend = r_mv_pend;
        n_mv_dst = r_mv_dst;
        n_res_status = r_res_status;
        n_res_off = r_res_off;
        n_res_gr = r_res_gr;
        n_ov = r_ov;
        n_o_status = r_o_status;
        n_o_off = r_o_off;
        n_o_gr = r_o_gr;
        tbl_ra = r_rd_idx[IW-1:0];
        tbl_we = 1'b0;
        tbl_wa = '0;
        tbl_wd = '0;
        st_we = 1'b0;
        gr_v = r_pick_bytes;
        st_wd = gr_v[STORE_W-1:0];

        if (r_ov && !i_stall) begin
            n_ov = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_op = i_opcode;
                    n_need = (VW'(i_request_bytes) + G_V - ONE_V) & ~(G_V - ONE_V);
                    n_node = node_v[AW-1:0];
                    n_res_status = ST_OK;
                    n_res_off = '0;
                    n_res_gr = '0;
                    n_rd_idx = '0;
                    n_chk_v = 1'b0;
                    n_found = 1'b0;
                    n_has_prev = 1'b0;
                    n_has_next = 1'b0;
                    if (i_opcode == OP_FREE && (off_v < G_V || off_v >= ARENA_V)) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // Reads are issued one entry ahead of the compare.
                if (r_rd_idx < r_count) begin
                    n_chk_v = 1'b1;
                    n_chk_idx = r_rd_idx;
                    n_rd_idx = r_rd_idx + ONE_C;
                end else begin
                    n_chk_v = 1'b0;
                end
                if (r_chk_v) begin
                    if (r_op == OP_ALLOC) begin
                        if (q_bytes >= r_need &&
                            (!r_found || (r_best && q_bytes < r_pick_bytes))) begin
                            n_found = 1'b1;
                            n_pick_idx = r_chk_idx;
                            n_pick_start = q_start;
                            n_pick_bytes = q_bytes;
                            if (!r_best) begin
                                n_state = S_ALLOC_DEC;
                            end
                        end
                    end else begin
                        if (r_node < q_start) begin
                            n_i = r_chk_idx;
                            n_has_next = 1'b1;
                            n_next_start = q_start;
                            n_next_bytes = q_bytes;
                            n_state = S_FREE_JOIN;
                        end else begin
                            n_has_prev = 1'b1;
                            n_prev_start = q_start;
                            n_prev_bytes = q_bytes;
                        end
                    end
                end else if (r_rd_idx >= r_count) begin
                    if (r_op == OP_ALLOC) begin
                        n_state = S_ALLOC_DEC;
                    end else begin
                        n_i = r_count;
                        n_has_next = 1'b0;
                        n_state = S_FREE_JOIN;
                    end
                end
            end
            S_ALLOC_DEC: begin
                if (!r_found) begin
                    n_res_status = ST_NO_FIT;
                    n_state = S_DONE;
                end else begin
                    st_we = 1'b1;
                    if (r_pick_bytes > r_need + G_V) begin
                        gr_v = r_need;
                        tbl_we = 1'b1;
                        tbl_wa = r_pick_idx[IW-1:0];
                        tbl_wd = {AW'(VW'(r_pick_start) + G_V + r_need),
                                  r_pick_bytes - G_V - r_need};
                        n_state = S_DONE;
                    end else begin
                        gr_v = r_pick_bytes;
                        n_count = r_count - ONE_C;
                        n_mv_up = 1'b0;
                        n_mv_pend = 1'b0;
                        n_mv_src = r_pick_idx + ONE_C;
                        n_mv_cnt = r_count - ONE_C - r_pick_idx;
                        n_state = S_MOVE;
                    end
                    st_wd = gr_v[STORE_W-1:0];
                    n_res_off = FIELD_W'(VW'(r_pick_start) + G_V);
                    n_res_gr = gr_v[FIELD_W-1:0];
                end
            end
            S_FREE_JOIN: begin
                n_jn = r_has_next && (VW'(r_node) + G_V + size_v == VW'(r_next_start));
                n_jp = r_has_prev && (VW'(r_prev_start) + G_V + r_prev_bytes == VW'(r_node));
                n_tail = size_v + G_V + r_next_bytes;
                n_mid = r_prev_bytes + G_V + size_v;
                n_state = S_FREE_DEC;
            end
            S_FREE_DEC: begin
                if (r_jn && r_jp) begin
                    tbl_we = 1'b1;
                    tbl_wa = im1[IW-1:0];
                    tbl_wd = {r_prev_start, r_mid + G_V + r_next_bytes};
                    n_count = r_count - ONE_C;
                    n_mv_up = 1'b0;
                    n_mv_pend = 1'b0;
                    n_mv_src = r_i + ONE_C;
                    n_mv_cnt = r_count - ONE_C - r_i;
                    n_state = S_MOVE;
                end else if (r_jn) begin
                    tbl_we = 1'b1;
                    tbl_wa = r_i[IW-1:0];
                    tbl_wd = {r_node, r_tail};
                    n_state = S_DONE;
                end else if (r_jp) begin
                    tbl_we = 1'b1;
                    tbl_wa = im1[IW-1:0];
                    tbl_wd = {r_prev_start, r_mid};
                    n_state = S_DONE;
                end else if (r_count >= MAX_C) begin
                    n_res_status = ST_FULL;
                    n_state = S_DONE;
                end else begin
                    n_mv_up = 1'b1;
                    n_mv_pend = 1'b0;
                    n_mv_src = r_count - ONE_C;
                    n_mv_cnt = r_count - r_i;
                    n_state = S_MOVE;
                end
            end
            S_MOVE: begin
                // Each entry is read, then written one slot over in the following cycle.
                if (r_mv_cnt != '0) begin
                    tbl_ra = r_mv_src[IW-1:0];
                    n_mv_pend = 1'b1;
                    n_mv_dst = r_mv_up ? r_mv_src + ONE_C : r_mv_src - ONE_C;
                    n_mv_src = r_mv_up ? r_mv_src - ONE_C : r_mv_src + ONE_C;
                    n_mv_cnt = r_mv_cnt - ONE_C;
                end else begin
                    n_mv_pend = 1'b0;
                end
                if (r_mv_pend) begin
                    tbl_we = 1'b1;
                    tbl_wa = r_mv_dst[IW-1:0];
                    tbl_wd = tbl_q;
                end
                if (r_mv_cnt == '0 && !r_mv_pend) begin
                    n_state = r_mv_up ? S_INS : S_DONE;
                end
            end
            S_INS: begin
                tbl_we = 1'b1;
                tbl_wa = r_i[IW-1:0];
                tbl_wd = {r_node, size_v};
                n_count = r_count + ONE_C;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ov || !i_stall) begin
                    n_ov = 1'b1;
                    n_o_status = r_res_status;
                    n_o_off = r_res_off;
                    n_o_gr = r_res_gr;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ov;
    assign o_status = r_o_status;
    assign o_data_offset = r_o_off;
    assign o_granted_bytes = r_o_gr;
    assign o_cfg_ready = 1'b1;

    `ASSERT_AT(a_count_max, 1'b1, r_count <= MAX_C)
    `ASSERT_NEXT(a_busy_after_accept, i_valid && !o_stall, o_stall)
    `ASSERT_AT(a_full_no_grant, o_valid && o_status == ST_FULL, o_data_offset == '0 && o_granted_bytes == '0)
    `ASSERT_AT(a_move_in_range, r_state == S_MOVE, r_count <= MAX_C && r_mv_cnt <= MAX_C)

endmodule

// ----- rtl/flba_seg_table.sv -----
module flba_seg_table import flba_pkg::*; #(
    parameter int DEPTH = 64,
    parameter int IW = 6,
    parameter int EW = 36,
    parameter logic [EW-1:0] INIT_ENTRY = '0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [IW-1:0] i_rd_addr,
    input  logic          i_wr_en,
    input  logic [IW-1:0] i_wr_addr,
    input  logic [EW-1:0] i_wr_data,
    output logic [EW-1:0] o_rd_data
);

    logic [EW-1:0] mem [DEPTH];
    logic [EW-1:0] r_q;
    logic          r_e0_init;
    logic          r_q_init;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        r_q <= mem[i_rd_addr];
    end

    // Entry zero reads as its reset value until it is first written.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e0_init <= 1'b1;
            r_q_init  <= 1'b0;
        end else begin
            if (i_wr_en && i_wr_addr == '0) begin
                r_e0_init <= 1'b0;
            end
            r_q_init <= (i_rd_addr == '0) && r_e0_init;
        end
    end

    assign o_rd_data = r_q_init ? INIT_ENTRY : r_q;

endmodule

// ----- sim/flba_checker.sv -----
`timescale 1ns / 100ps

module flba_checker import flba_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               o_stall,
    input  logic               i_opcode,
    input  logic [FIELD_W-1:0] i_request_bytes,
    input  logic [FIELD_W-1:0] i_free_offset_in,
    input  logic               o_valid,
    input  logic               i_stall,
    input  logic [1:0]         o_status,
    input  logic [FIELD_W-1:0] o_data_offset,
    input  logic [FIELD_W-1:0] o_granted_bytes,
    input  logic               i_cfg_valid,
    input  logic               o_cfg_ready,
    input  logic               i_cfg_best_fit_mode,
    output int                 o_pending,
    output int                 o_fail_count,
    output int                 o_grants,
    output int                 o_no_fits,
    output int                 o_table_fulls,
    output int                 o_frees
);

    localparam int ARENA    = 65536;
    localparam int SEGS     = 64;
    localparam int GRANULE  = 16;

    typedef struct packed {
        logic [1:0]         status;
        logic [FIELD_W-1:0] data_offset;
        logic [FIELD_W-1:0] granted;
    } reply_t;

    reply_t reply_q[$];

    int  seg_start [SEGS];
    int  seg_bytes [SEGS];
    int  seg_count;
    int  block_size [ARENA / GRANULE];
    bit  best_fit;

    function automatic void drop_segment(input int idx);
        int k;
        for (k = idx; k + 1 < seg_count; k++) begin
            seg_start[k] = seg_start[k + 1];
            seg_bytes[k] = seg_bytes[k + 1];
        end
        seg_count--;
    endfunction

    function automatic reply_t allocate_block(input int req);
        reply_t r;
        int     need, pick, hdr, granted, i;
        bit     found;
        r = '{ST_OK, '0, '0};
        need = (req + GRANULE - 1) / GRANULE * GRANULE;
        found = 0;
        pick = 0;
        for (i = 0; i < seg_count; i++) begin
            if (seg_bytes[i] >= need &&
                (!found || (best_fit && seg_bytes[i] < seg_bytes[pick]))) begin
                pick = i;
                found = 1;
                if (!best_fit) break;
            end
        end
        if (!found) begin
            r.status = ST_NO_FIT;
            o_no_fits++;
            return r;
        end
        hdr = seg_start[pick];
        // Split only when the leftover still holds a header plus at least one byte.
        if (seg_bytes[pick] >= need + GRANULE + 1) begin
            seg_start[pick] = hdr + GRANULE + need;
            seg_bytes[pick] = seg_bytes[pick] - GRANULE - need;
            granted = need;
        end else begin
            granted = seg_bytes[pick];
            drop_segment(pick);
        end
        block_size[hdr / GRANULE] = granted & 'h1FFFF;
        r.data_offset = FIELD_W'(hdr + GRANULE);
        r.granted = FIELD_W'(granted);
        o_grants++;
        return r;
    endfunction

    function automatic reply_t release_block(input int off);
        reply_t r;
        int     node, size, i, k;
        bit     join_next, join_prev;
        r = '{ST_OK, '0, '0};
        o_frees++;
        if (off < GRANULE || off >= ARENA) return r;
        node = off - GRANULE;
        size = block_size[node / GRANULE];
        for (i = 0; i < seg_count; i++)
            if (node < seg_start[i]) break;
        join_next = i < seg_count && node + GRANULE + size == seg_start[i];
        join_prev = i > 0 && seg_start[i - 1] + GRANULE + seg_bytes[i - 1] == node;
        if (join_next && join_prev) begin
            seg_bytes[i - 1] += GRANULE + size + GRANULE + seg_bytes[i];
            drop_segment(i);
        end else if (join_next) begin
            seg_start[i] = node;
            seg_bytes[i] = size + GRANULE + seg_bytes[i];
        end else if (join_prev) begin
            seg_bytes[i - 1] += GRANULE + size;
        end else if (seg_count >= SEGS) begin
            r.status = ST_FULL;
            o_table_fulls++;
        end else begin
            for (k = seg_count; k > i; k--) begin
                seg_start[k] = seg_start[k - 1];
                seg_bytes[k] = seg_bytes[k - 1];
            end
            seg_start[i] = node;
            seg_bytes[i] = size;
            seg_count++;
        end
        return r;
    endfunction

    initial begin
        o_fail_count = 0;
        o_grants = 0;
        o_no_fits = 0;
        o_table_fulls = 0;
        o_frees = 0;
        best_fit = 0;
        seg_count = 1;
        seg_start[0] = 0;
        seg_bytes[0] = ARENA - GRANULE;
        foreach (block_size[i]) block_size[i] = 0;
    end

    assign o_pending = reply_q.size();

    always @(posedge i_clk) begin
        reply_t want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) best_fit = i_cfg_best_fit_mode;

            if (o_valid && !i_stall) begin
                if (reply_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("%0t: result word with nothing expected: status %0d",
                                 $time, o_status);
                end else begin
                    want = reply_q.pop_front();
                    if (o_status !== want.status || o_data_offset !== want.data_offset ||
                        o_granted_bytes !== want.granted) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("%0t: mismatch: expected status %0d offset %0d granted %0d, got status %0d offset %0d granted %0d",
                                     $time, want.status, want.data_offset, want.granted,
                                     o_status, o_data_offset, o_granted_bytes);
                    end
                end
            end

            if (i_valid && !o_stall) begin
                if (i_opcode == OP_ALLOC)
                    reply_q.push_back(allocate_block(int'(i_request_bytes)));
                else
                    reply_q.push_back(release_block(int'(i_free_offset_in)));
            end
        end
    end

endmodule

// ----- sim/tb_free_list_block_allocator_core.sv -----
`timescale 1ns / 100ps

module tb_free_list_block_allocator_core;
    import flba_pkg::*;

    localparam int DRAIN_CYCLES = 2 * 64 + 20;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic               i_opcode;
    logic [FIELD_W-1:0] i_request_bytes;
    logic [FIELD_W-1:0] i_free_offset_in;
    logic               o_valid;
    logic               i_stall;
    logic [1:0]         o_status;
    logic [FIELD_W-1:0] o_data_offset;
    logic [FIELD_W-1:0] o_granted_bytes;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic               i_cfg_best_fit_mode;

    int pending, fail_count, grants, no_fits, table_fulls, frees;

    int         send_idle_pct;
    int         stall_pct;
    logic       sent_ops[$];
    int         live_blocks[$];
    int         last_freed;

    free_list_block_allocator_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_opcode(i_opcode),
        .i_request_bytes(i_request_bytes), .i_free_offset_in(i_free_offset_in),
        .o_valid(o_valid), .i_stall(i_stall), .o_status(o_status),
        .o_data_offset(o_data_offset), .o_granted_bytes(o_granted_bytes),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_best_fit_mode(i_cfg_best_fit_mode)
    );

    flba_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_opcode(i_opcode),
        .i_request_bytes(i_request_bytes), .i_free_offset_in(i_free_offset_in),
        .o_valid(o_valid), .i_stall(i_stall), .o_status(o_status),
        .o_data_offset(o_data_offset), .o_granted_bytes(o_granted_bytes),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_best_fit_mode(i_cfg_best_fit_mode),
        .o_pending(pending), .o_fail_count(fail_count), .o_grants(grants),
        .o_no_fits(no_fits), .o_table_fulls(table_fulls), .o_frees(frees)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    // Granted offsets become candidates for later frees once their word returns.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall && sent_ops.size() > 0) begin
            if (sent_ops.pop_front() == OP_ALLOC && o_status == ST_OK)
                live_blocks.push_back(int'(o_data_offset));
        end
    end

    task automatic send_word(input logic op, input int req, input int off);
        i_valid <= 1'b1;
        i_opcode <= op;
        i_request_bytes <= FIELD_W'(req);
        i_free_offset_in <= FIELD_W'(off);
        do @(posedge i_clk); while (o_stall);
        sent_ops.push_back(op);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge i_clk);
        end
    endtask

    task automatic free_live(input int idx);
        int off;
        off = live_blocks[idx];
        live_blocks.delete(idx);
        last_freed = off;
        send_word(OP_FREE, $urandom, off);
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic mode);
        i_cfg_valid <= 1'b1;
        i_cfg_best_fit_mode <= mode;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Frees every live block, chops the arena into many small blocks and frees every
    // other one so the segment table fills up; the rest are freed afterward to merge back.
    task automatic fragment_arena;
        int n, i;
        drain;
        while (live_blocks.size() > 0) free_live($urandom_range(live_blocks.size() - 1));
        drain;
        n = $urandom_range(150, 135);
        for (i = 0; i < n; i++) send_word(OP_ALLOC, $urandom_range(32), $urandom);
        drain;
        for (i = live_blocks.size() - 2; i >= 0; i -= 2) free_live(i);
        drain;
        while (live_blocks.size() > 0) free_live($urandom_range(live_blocks.size() - 1));
        drain;
    endtask

    task automatic random_traffic(input int count);
        int i, pick, req;
        for (i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (live_blocks.size() == 0 || pick < (live_blocks.size() < 40 ? 60 : 35)) begin
                pick = $urandom_range(99);
                if (pick < 80) req = $urandom_range(300);
                else if (pick < 95) req = $urandom_range(8192);
                else req = $urandom_range(65535);
                send_word(OP_ALLOC, req, $urandom);
            end else if (pick < 96) begin
                free_live($urandom_range(live_blocks.size() - 1));
            end else if (pick < 99) begin
                send_word(OP_FREE, $urandom, $urandom_range(15));
            end else begin
                // A repeated free is trusted by the block and must be handled alike.
                send_word(OP_FREE, $urandom, last_freed);
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_opcode = OP_ALLOC;
        i_request_bytes = '0;
        i_free_offset_in = '0;
        i_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_best_fit_mode = 1'b0;
        send_idle_pct = 0;
        stall_pct = 0;
        last_freed = 16;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_mode(1'b0);

        send_word(OP_ALLOC, 0, 0);
        send_word(OP_ALLOC, 1, 'hFFFF);
        send_word(OP_ALLOC, 16, 0);
        send_word(OP_ALLOC, 17, 0);
        send_word(OP_ALLOC, 'hFFFF, 0);
        send_word(OP_ALLOC, 1000, 0);
        send_word(OP_FREE, 0, 0);
        send_word(OP_FREE, 'hFFFF, 15);
        drain;
        free_live(1);
        free_live(0);
        free_live(2);
        free_live(0);
        drain;
        free_live(0);
        drain;
        send_word(OP_ALLOC, 65520, 0);
        send_word(OP_ALLOC, 0, 0);
        drain;
        free_live(0);
        drain;
        write_mode(1'b1);
        send_word(OP_ALLOC, 100, 0);
        send_word(OP_ALLOC, 300, 0);
        send_word(OP_ALLOC, 100, 0);
        send_word(OP_ALLOC, 40000, 0);
        drain;
        free_live(0);
        free_live(1);
        send_word(OP_ALLOC, 90, 0);
        drain;

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 75; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 75; end
                default: begin send_idle_pct = 8; stall_pct = 8; end
            endcase
            drain;
            write_mode(phase[0]);
            if (phase != 1) fragment_arena;
            random_traffic(40);
        end
        drain;

        $display("Covered %0d grants, %0d no-fit replies, %0d table-full replies, %0d frees,",
                 grants, no_fits, table_fulls, frees);
        $display("under first fit and best fit with idle and stall patterns on both sides.");
        if (fail_count == 0)
            $display("tb_free_list_block_allocator_core passed");
        else
            $display("tb_free_list_block_allocator_core failed");
        $finish;
    end

    initial begin
        #60_000_000;
        $display("tb_free_list_block_allocator_core failed");
        $finish;
    end

endmodule
